FILE: rtl/swm_pkg.sv
// swm_pkg: shared types and constants for the sorted two-way merge block
// used by swm_ctrl, swm_dp, the top level and the checker; no dependencies
package swm_pkg;

    localparam int DATA_W = 32;
    localparam int MODE_W = 2;

    // input item codes
    localparam logic [MODE_W-1:0] MODE_APPEND_A = 2'd0;
    localparam logic [MODE_W-1:0] MODE_APPEND_B = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MERGE    = 2'd2;
    localparam logic [MODE_W-1:0] MODE_UNUSED   = 2'd3;

    // commands from the controller to the datapath
    typedef struct packed {
        logic wr_a;     // append the input value to sequence a
        logic wr_b;     // append the input value to sequence b
        logic fire;     // register one merged result and advance its pointer
        logic clear;    // empty both sequences and rewind the pointers
    } t_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic empty;    // both sequences hold no entries
        logic out_free; // output register can take a result this cycle
        logic last;     // the current pick is the final one of the merge
    } t_status;

endpackage

FILE: rtl/sorted_two_way_merge.sv
// after a merge transfer the controller passes through S_LOAD (head fetch from the
// registered-read rams) and registers the first result in S_EMIT once the output is free
// throughput: one result per cycle while the output side takes them; new items are
// accepted again the cycle after the final result is registered
// reset: synchronous active-low clears counts, pointers, loss flag and output valid;
// buffer contents are left as they are
// top level of the sorted two-way merge; depends on swm_pkg, swm_ctrl and swm_dp
module sorted_two_way_merge #(
    parameter int DEPTH = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [swm_pkg::MODE_W-1:0]        i_in_mode,
    input  logic signed [swm_pkg::DATA_W-1:0] i_in_value,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [swm_pkg::DATA_W-1:0] o_merged_value,
    output logic                              o_from_b,
    output logic                              o_last,
    output logic                              o_dropped
);

    swm_pkg::t_cmd    cmd;
    swm_pkg::t_status status;

    // sequencing of appends and merge steps
    swm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_mode  (i_in_mode),
        .i_status   (status),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    // buffers, pointers and output register
    swm_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_in_value     (i_in_value),
        .i_out_ready    (i_out_ready),
        .o_status       (status),
        .o_out_valid    (o_out_valid),
        .o_merged_value (o_merged_value),
        .o_from_b       (o_from_b),
        .o_last         (o_last),
        .o_dropped      (o_dropped)
    );

endmodule

FILE: rtl/swm_ram.sv
// swm_ram: generic simple dual-port ram, one write port and one registered read port
// no dependencies
module swm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                     i_wr_data,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                     o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/swm_ctrl.sv
// swm_ctrl: controller state machine of the merge block
// depends on swm_pkg for the command and status structs and item codes
module swm_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic [swm_pkg::MODE_W-1:0]    i_in_mode,
    input  swm_pkg::t_status              i_status,
    output logic                          o_in_ready,
    output swm_pkg::t_cmd                 o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_ready;
    logic   n_ready;
    logic   accept;
    logic   fire;

    assign accept = i_in_valid && r_ready;
    assign fire   = (r_state == S_EMIT) && i_status.out_free;

    // commands to the datapath
    always_comb begin
        o_cmd       = '0;
        o_cmd.fire  = fire;
        o_cmd.clear = fire && i_status.last;
        unique case (i_in_mode)
            swm_pkg::MODE_APPEND_A: o_cmd.wr_a = accept;
            swm_pkg::MODE_APPEND_B: o_cmd.wr_b = accept;
            swm_pkg::MODE_MERGE,
            swm_pkg::MODE_UNUSED:   o_cmd.wr_a = 1'b0;
            default:                o_cmd.wr_a = 1'b0;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_ready = r_ready;
        unique case (r_state)
            S_IDLE: begin
                // a merge over two empty sequences gives nothing
                if (accept && i_in_mode == swm_pkg::MODE_MERGE && !i_status.empty) begin
                    n_state = S_LOAD;
                    n_ready = 1'b0;
                end
            end
            // S_LOAD lets the head reads see the latest appends
            S_LOAD: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (fire && i_status.last) begin
                    n_state = S_IDLE;
                    n_ready = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
                n_ready = 1'b1;
            end
        endcase
    end

    // state and registered ready
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ready <= 1'b1;
        end else begin
            r_state <= n_state;
            r_ready <= n_ready;
        end
    end

    assign o_in_ready = r_ready;

endmodule

FILE: rtl/swm_dp.sv
// swm_dp: datapath of the merge block: sequence rams, counts, read pointers,
// head compare and output register; depends on swm_pkg and swm_ram
module swm_dp #(
    parameter int DEPTH = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  swm_pkg::t_cmd                     i_cmd,
    input  logic signed [swm_pkg::DATA_W-1:0] i_in_value,
    input  logic                              i_out_ready,
    output swm_pkg::t_status                  o_status,
    output logic                              o_out_valid,
    output logic signed [swm_pkg::DATA_W-1:0] o_merged_value,
    output logic                              o_from_b,
    output logic                              o_last,
    output logic                              o_dropped
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    logic [CW-1:0] r_cnt_a, n_cnt_a;
    logic [CW-1:0] r_cnt_b, n_cnt_b;
    logic [CW-1:0] r_ptr_a, n_ptr_a;
    logic [CW-1:0] r_ptr_b, n_ptr_b;
    logic          r_lost, n_lost;
    logic          full_a, full_b;
    logic          we_a, we_b;
    logic          exh_a, exh_b;
    logic          pick_b;
    logic          last_pick;
    logic signed [swm_pkg::DATA_W-1:0] head_a, head_b;

    logic                              r_out_valid;
    logic signed [swm_pkg::DATA_W-1:0] r_out_value;
    logic                              r_out_from_b;
    logic                              r_out_last;
    logic                              r_out_dropped;

    // appends to a full buffer are lost
    assign full_a = (r_cnt_a == FULL);
    assign full_b = (r_cnt_b == FULL);
    assign we_a   = i_cmd.wr_a && !full_a;
    assign we_b   = i_cmd.wr_b && !full_b;

    // head selection: an exhausted side loses; otherwise a wins only when strictly smaller
    assign exh_a  = (r_ptr_a == r_cnt_a);
    assign exh_b  = (r_ptr_b == r_cnt_b);
    assign pick_b = exh_a || (!exh_b && !(head_a < head_b));
    assign last_pick = pick_b ? ((r_ptr_b + CW'(1) == r_cnt_b) && exh_a)
                              : ((r_ptr_a + CW'(1) == r_cnt_a) && exh_b);

    // counts, pointers and loss flag
    always_comb begin
        n_cnt_a = r_cnt_a;
        n_cnt_b = r_cnt_b;
        n_ptr_a = r_ptr_a;
        n_ptr_b = r_ptr_b;
        n_lost  = r_lost;
        if (we_a) begin
            n_cnt_a = r_cnt_a + CW'(1);
        end
        if (we_b) begin
            n_cnt_b = r_cnt_b + CW'(1);
        end
        if ((i_cmd.wr_a && full_a) || (i_cmd.wr_b && full_b)) begin
            n_lost = 1'b1;
        end
        if (i_cmd.fire) begin
            if (pick_b) begin
                n_ptr_b = r_ptr_b + CW'(1);
            end else begin
                n_ptr_a = r_ptr_a + CW'(1);
            end
        end
        if (i_cmd.clear) begin
            n_cnt_a = '0;
            n_cnt_b = '0;
            n_ptr_a = '0;
            n_ptr_b = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_a <= '0;
            r_cnt_b <= '0;
            r_ptr_a <= '0;
            r_ptr_b <= '0;
            r_lost  <= 1'b0;
        end else begin
            r_cnt_a <= n_cnt_a;
            r_cnt_b <= n_cnt_b;
            r_ptr_a <= n_ptr_a;
            r_ptr_b <= n_ptr_b;
            r_lost  <= n_lost;
        end
    end

    // sequence buffers; the read address follows the next pointer so the
    // registered read data is the head at the current pointer
    swm_ram #(
        .WIDTH (swm_pkg::DATA_W),
        .DEPTH (DEPTH)
    ) u_ram_a (
        .i_clk     (i_clk),
        .i_wr_en   (we_a),
        .i_wr_addr (r_cnt_a[AW-1:0]),
        .i_wr_data (i_in_value),
        .i_rd_addr (n_ptr_a[AW-1:0]),
        .o_rd_data (head_a)
    );

    swm_ram #(
        .WIDTH (swm_pkg::DATA_W),
        .DEPTH (DEPTH)
    ) u_ram_b (
        .i_clk     (i_clk),
        .i_wr_en   (we_b),
        .i_wr_addr (r_cnt_b[AW-1:0]),
        .i_wr_data (i_in_value),
        .i_rd_addr (n_ptr_b[AW-1:0]),
        .o_rd_data (head_b)
    );

    // output register: valid is control, the rest is payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fire) begin
            r_out_value   <= pick_b ? head_b : head_a;
            r_out_from_b  <= pick_b;
            r_out_last    <= last_pick;
            r_out_dropped <= r_lost;
        end
    end

    // status to the controller
    assign o_status.empty    = (r_cnt_a == '0) && (r_cnt_b == '0);
    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_status.last     = last_pick;

    assign o_out_valid    = r_out_valid;
    assign o_merged_value = r_out_value;
    assign o_from_b       = r_out_from_b;
    assign o_last         = r_out_last;
    assign o_dropped      = r_out_dropped;

endmodule

FILE: rtl/swm_checker.sv
// swm_checker: port-level assertions for sorted_two_way_merge, bound to the top level
// depends on swm_pkg for the item codes
module swm_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              o_in_ready,
    input  logic [swm_pkg::MODE_W-1:0]        i_in_mode,
    input  logic                              o_out_valid,
    input  logic                              i_out_ready,
    input  logic signed [swm_pkg::DATA_W-1:0] o_merged_value,
    input  logic                              o_last
);

    // a stalled result holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_merged_value))
        else $error("stalled result changed");

    // while a merge is still running no new item is taken
    a_busy_no_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last |-> !o_in_ready)
        else $error("input ready during an unfinished merge");

    // an append or unused-mode transfer never brings a result
    a_append_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_in_mode != swm_pkg::MODE_MERGE) && !o_out_valid
        |=> !o_out_valid)
        else $error("result after a non-merge transfer");

    // reset leaves the block idle and ready
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("not idle after reset");

endmodule

bind sorted_two_way_merge swm_checker u_swm_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .i_in_mode      (i_in_mode),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_merged_value (o_merged_value),
    .o_last         (o_last)
);

FILE: dv/tb_top.sv
// tb_top: self-checking testbench for sorted_two_way_merge with its own merge predictor
// covers directed corner cases, mostly sorted random runs, random idling and a full-buffer run
// depends on swm_pkg and the sorted_two_way_merge rtl
module tb_top;

    localparam int DEPTH       = 32;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_PAD   = 16;
    localparam int RANDOM_LOADS = 135;

    localparam logic signed [swm_pkg::DATA_W-1:0] VAL_MIN =
        {1'b1, {(swm_pkg::DATA_W-1){1'b0}}};
    localparam logic signed [swm_pkg::DATA_W-1:0] VAL_MAX =
        {1'b0, {(swm_pkg::DATA_W-1){1'b1}}};

    // one merged output word as the block should present it
    typedef struct packed {
        logic signed [swm_pkg::DATA_W-1:0] value;
        logic                              from_b;
        logic                              last;
        logic                              dropped;
    } t_merged_word;

    // dut ports
    logic                              i_clk       = 1'b0;
    logic                              i_rst_n     = 1'b0;
    logic                              i_in_valid  = 1'b0;
    logic [swm_pkg::MODE_W-1:0]        i_in_mode   = swm_pkg::MODE_APPEND_A;
    logic signed [swm_pkg::DATA_W-1:0] i_in_value  = '0;
    logic                              i_out_ready = 1'b0;
    logic                              o_in_ready;
    logic                              o_out_valid;
    logic signed [swm_pkg::DATA_W-1:0] o_merged_value;
    logic                              o_from_b;
    logic                              o_last;
    logic                              o_dropped;

    // shadow copy of the two sequences and the sticky loss flag
    logic signed [swm_pkg::DATA_W-1:0] seq_a_shadow[$];
    logic signed [swm_pkg::DATA_W-1:0] seq_b_shadow[$];
    logic                              lost_shadow = 1'b0;

    // merged words still owed by the block, oldest first
    t_merged_word expected_merge_out[$];

    int mismatch_count = 0;
    int loads_sent     = 0;
    int burst_left     = 0;
    int stall_left     = 0;
    int rx_cycle       = 0;

    sorted_two_way_merge #(
        .DEPTH(DEPTH)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_in_mode      (i_in_mode),
        .i_in_value     (i_in_value),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_merged_value (o_merged_value),
        .o_from_b       (o_from_b),
        .o_last         (o_last),
        .o_dropped      (o_dropped)
    );

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("tb: failure");
        $finish;
    end

    // predictor: apply one accepted item to the shadow state
    task automatic update_merge_shadow(input logic [swm_pkg::MODE_W-1:0] mode,
                                       input logic signed [swm_pkg::DATA_W-1:0] value);
        int           na;
        int           nb;
        int           ia;
        int           ib;
        t_merged_word word;
        case (mode)
            swm_pkg::MODE_APPEND_A: begin
                if (seq_a_shadow.size() >= DEPTH) lost_shadow = 1'b1;
                else seq_a_shadow.push_back(value);
            end
            swm_pkg::MODE_APPEND_B: begin
                if (seq_b_shadow.size() >= DEPTH) lost_shadow = 1'b1;
                else seq_b_shadow.push_back(value);
            end
            swm_pkg::MODE_MERGE: begin
                na = seq_a_shadow.size();
                nb = seq_b_shadow.size();
                ia = 0;
                ib = 0;
                for (int k = 0; k < na + nb; k++) begin
                    // an exhausted side loses; otherwise a wins only when strictly smaller and ties go to b
                    if (ia >= na) word.from_b = 1'b1;
                    else if (ib >= nb) word.from_b = 1'b0;
                    else word.from_b = (seq_a_shadow[ia] < seq_b_shadow[ib]) ? 1'b0 : 1'b1;
                    if (word.from_b) begin
                        word.value = seq_b_shadow[ib];
                        ib++;
                    end else begin
                        word.value = seq_a_shadow[ia];
                        ia++;
                    end
                    word.last    = (k == na + nb - 1);
                    word.dropped = lost_shadow;
                    expected_merge_out.push_back(word);
                end
                seq_a_shadow.delete();
                seq_b_shadow.delete();
            end
            default: begin
            end
        endcase
    endtask

    // send one item: bursts with random gaps, valid held until the transfer
    task automatic send_item(input logic [swm_pkg::MODE_W-1:0] mode,
                             input logic signed [swm_pkg::DATA_W-1:0] value);
        if (burst_left == 0) begin
            i_in_valid <= 1'b0;
            if ($urandom_range(0, 7) == 0) repeat ($urandom_range(8, 20)) @(posedge i_clk);
            else repeat ($urandom_range(1, 4)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 12);
        end
        i_in_valid <= 1'b1;
        i_in_mode  <= mode;
        i_in_value <= value;
        do @(posedge i_clk); while (!o_in_ready);
        update_merge_shadow(mode, value);
        burst_left--;
        if (mode != swm_pkg::MODE_UNUSED) loads_sent++;
    endtask

    // stop sending and wait until every owed word has come out
    task automatic drain_merge_output;
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (expected_merge_out.size() != 0) @(posedge i_clk);
        repeat (DRAIN_PAD) @(posedge i_clk);
    endtask

    // compare one output transfer with the oldest expected word
    task automatic check_merge_output;
        t_merged_word got;
        t_merged_word want;
        string        want_txt;
        string        got_txt;
        got = '{o_merged_value, o_from_b, o_last, o_dropped};
        if (expected_merge_out.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("mismatch: unexpected word value=%0d from_b=%0b last=%0b dropped=%0b",
                         got.value, got.from_b, got.last, got.dropped);
        end else begin
            want = expected_merge_out.pop_front();
            if (got !== want) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    want_txt = $sformatf("value=%0d from_b=%0b last=%0b dropped=%0b",
                                         want.value, want.from_b, want.last, want.dropped);
                    got_txt  = $sformatf("value=%0d from_b=%0b last=%0b dropped=%0b",
                                         got.value, got.from_b, got.last, got.dropped);
                    $display("mismatch: expected %s, got %s", want_txt, got_txt);
                end
            end
        end
    endtask

    // output side: check each transfer, then pick ready from a rotating stall pattern
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) check_merge_output();
        rx_cycle = rx_cycle + 1;
        case ((rx_cycle / 300) % 4)
            0: i_out_ready <= 1'b1;
            1: i_out_ready <= ($urandom_range(0, 1) == 1);
            2: i_out_ready <= ((rx_cycle % 8) > 2);
            default: begin
                if (stall_left > 0) begin
                    stall_left = stall_left - 1;
                    i_out_ready <= 1'b0;
                end else if ($urandom_range(0, 7) == 0) begin
                    stall_left = $urandom_range(1, 15);
                    i_out_ready <= 1'b0;
                end else begin
                    i_out_ready <= 1'b1;
                end
            end
        endcase
    end

    // random run length, mostly short with an occasional long one
    function automatic int pick_run_length();
        if ($urandom_range(0, 9) == 0) return $urandom_range(20, DEPTH);
        return $urandom_range(0, 6);
    endfunction

    // build one run of values; narrow values force ties, shuffled runs stay unsorted
    function automatic void fill_run(ref logic signed [swm_pkg::DATA_W-1:0] run[$],
                                     input int n, input bit narrow, input bit shuffled);
        logic signed [swm_pkg::DATA_W-1:0] v;
        run.delete();
        repeat (n) begin
            if (narrow) v = $urandom_range(0, 12) - 6;
            else v = $urandom;
            run.push_back(v);
        end
        if (!shuffled) run.sort();
    endfunction

    // merge with nothing stored and the unused mode
    task automatic test_empty_and_unused;
        send_item(swm_pkg::MODE_MERGE, VAL_MAX);
        send_item(swm_pkg::MODE_UNUSED, VAL_MAX);
        send_item(swm_pkg::MODE_UNUSED, VAL_MIN);
        send_item(swm_pkg::MODE_MERGE, VAL_MIN);
    endtask

    // extreme values and equal heads on both sides
    task automatic test_extremes_and_ties;
        send_item(swm_pkg::MODE_APPEND_A, VAL_MIN);
        send_item(swm_pkg::MODE_APPEND_B, VAL_MIN);
        send_item(swm_pkg::MODE_APPEND_A, -1);
        send_item(swm_pkg::MODE_APPEND_B, -1);
        send_item(swm_pkg::MODE_APPEND_A, 5);
        send_item(swm_pkg::MODE_APPEND_B, VAL_MAX);
        send_item(swm_pkg::MODE_MERGE, '0);
    endtask

    // only one sequence holds data
    task automatic test_single_sided;
        send_item(swm_pkg::MODE_APPEND_A, VAL_MAX);
        send_item(swm_pkg::MODE_MERGE, -1);
        send_item(swm_pkg::MODE_APPEND_B, VAL_MIN);
        send_item(swm_pkg::MODE_APPEND_B, '0);
        send_item(swm_pkg::MODE_MERGE, '0);
    endtask

    // descending input still follows the head comparison
    task automatic test_unsorted;
        send_item(swm_pkg::MODE_APPEND_A, 10);
        send_item(swm_pkg::MODE_APPEND_A, 3);
        send_item(swm_pkg::MODE_APPEND_B, 7);
        send_item(swm_pkg::MODE_APPEND_B, 1);
        send_item(swm_pkg::MODE_MERGE, '0);
    endtask

    // random runs loaded in random interleave, each followed by a merge
    task automatic test_random_merges;
        logic signed [swm_pkg::DATA_W-1:0] run_a[$];
        logic signed [swm_pkg::DATA_W-1:0] run_b[$];
        int base_count;
        bit narrow;
        bit shuffled;
        base_count = loads_sent;
        while (loads_sent - base_count < RANDOM_LOADS) begin
            narrow   = ($urandom_range(0, 2) == 0);
            shuffled = ($urandom_range(0, 7) == 0);
            fill_run(run_a, pick_run_length(), narrow, shuffled);
            fill_run(run_b, pick_run_length(), narrow, shuffled);
            while (run_a.size() + run_b.size() > 0) begin
                if ($urandom_range(0, 15) == 0) send_item(swm_pkg::MODE_UNUSED, $urandom);
                if (run_b.size() == 0 || (run_a.size() != 0 && $urandom_range(0, 1) == 1))
                    send_item(swm_pkg::MODE_APPEND_A, run_a.pop_front());
                else
                    send_item(swm_pkg::MODE_APPEND_B, run_b.pop_front());
            end
            send_item(swm_pkg::MODE_MERGE, $urandom);
        end
    endtask

    // overfill both buffers, then check the loss flag survives the next merge
    task automatic test_full_buffer;
        logic signed [swm_pkg::DATA_W-1:0] run_a[$];
        logic signed [swm_pkg::DATA_W-1:0] run_b[$];
        fill_run(run_a, DEPTH + 2, 1'b0, 1'b0);
        fill_run(run_b, DEPTH + 1, 1'b0, 1'b0);
        while (run_a.size() != 0) send_item(swm_pkg::MODE_APPEND_A, run_a.pop_front());
        while (run_b.size() != 0) send_item(swm_pkg::MODE_APPEND_B, run_b.pop_front());
        send_item(swm_pkg::MODE_MERGE, $urandom);
        send_item(swm_pkg::MODE_APPEND_A, 7);
        send_item(swm_pkg::MODE_APPEND_B, 7);
        send_item(swm_pkg::MODE_MERGE, $urandom);
    endtask

    // main sequence
    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_and_unused();
        test_extremes_and_ties();
        test_single_sided();
        test_unsorted();
        test_random_merges();
        test_full_buffer();
        drain_merge_output();
        if (mismatch_count == 0 && expected_merge_out.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
